// File: hdl/hkrt_pkg.sv
// Shared types and constants for the HID keyboard report tracker.
package hkrt_pkg;

    // Number of key slots that the result item carries
    localparam int unsigned OUT_SLOTS = 6;

    // Request codes on the item channel
    typedef enum logic [2:0] {
        OP_ADD_KEY   = 3'd0,
        OP_DEL_KEY   = 3'd1,
        OP_ADD_MODS  = 3'd2,
        OP_DEL_MODS  = 3'd3,
        OP_SET_CONS  = 3'd4,
        OP_CLR_KB    = 3'd5,
        OP_CLR_CONS  = 3'd6
    } t_op;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } t_state;

endpackage

// File: hdl/hkrt_item_if.sv
// Request channel: valid/ready handshake with the request payload.
interface hkrt_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  key_code;
    logic [7:0]  modifier_bits;
    logic [15:0] consumer_value;

    modport source (output valid, op, key_code, modifier_bits, consumer_value, input ready);
    modport sink   (input valid, op, key_code, modifier_bits, consumer_value, output ready);
endinterface

// File: hdl/hkrt_result_if.sv
// Result channel: valid/ready handshake with the full report snapshot.
interface hkrt_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  key_slot_0;
    logic [7:0]  key_slot_1;
    logic [7:0]  key_slot_2;
    logic [7:0]  key_slot_3;
    logic [7:0]  key_slot_4;
    logic [7:0]  key_slot_5;
    logic [7:0]  modifier_state;
    logic [15:0] consumer_state;
    logic        keyboard_dirty;
    logic        consumer_dirty;

    modport source (
        output valid, key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4,
               key_slot_5, modifier_state, consumer_state, keyboard_dirty,
               consumer_dirty,
        input  ready
    );
    modport sink (
        input  valid, key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4,
               key_slot_5, modifier_state, consumer_state, keyboard_dirty,
               consumer_dirty,
        output ready
    );
endinterface

// File: hdl/hid_keyboard_report_tracker.sv
// HID keyboard report tracker: key slots, modifiers, consumer usage, dirty flags.
//
// Usage: requests arrive on i_item (valid/ready); each request yields exactly one
// result item on o_result carrying all key slots, the modifier byte, the
// consumer usage word and both sticky dirty flags after the request applied.
// One request is handled at a time: i_item.ready is high only when the block is
// idle. A single slot comparator is stepped over the slot registers by a small
// sequencer, one slot per cycle.
// Modifier, consumer and flag-clear requests, and key code zero, skip the slot scan.
// A key add scans until a match, the first empty slot or the last slot; a key
// remove searches for the key, then shifts the slots behind it down one slot at
// a time and clears the last slot. The block returns to idle after each result.
// The result is held on o_result until taken; while o_result.ready is low the
// block accepts no request. Synchronous reset clears all slots, the modifier
// byte, the consumer word and both flags, and leaves both channels idle.
// Slots at or beyond KEY_SLOTS read 0; only the first six slots are visible.
module hid_keyboard_report_tracker #(
    parameter int unsigned KEY_SLOTS = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hkrt_item_if.sink      i_item,
    hkrt_result_if.source  o_result
);

    localparam int unsigned IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    hkrt_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_slots [KEY_SLOTS];
    logic [7:0]       r_mods, n_mods;
    logic [15:0]      r_cons, n_cons;
    logic             r_kb_dirty, n_kb_dirty;
    logic             r_cons_dirty, n_cons_dirty;

    // Latched request
    logic [2:0]       r_op;
    logic [7:0]       r_code;
    logic [7:0]       r_mbits;
    logic [15:0]      r_usage;

    // Shared slot comparator and slot write port
    logic [7:0]       w_cur;
    logic             w_hit, w_empty, w_last, w_key_op;
    logic             w_wr_en;
    logic [7:0]       w_wr_data;
    logic [7:0]       w_view [hkrt_pkg::OUT_SLOTS];

    assign w_cur    = r_slots[r_idx];
    assign w_hit    = (w_cur == r_code);
    assign w_empty  = (w_cur == 8'd0);
    assign w_last   = (r_idx == LAST_IDX);
    assign w_key_op = ((r_op == hkrt_pkg::OP_ADD_KEY) || (r_op == hkrt_pkg::OP_DEL_KEY))
                      && (r_code != 8'd0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hkrt_pkg::ST_IDLE: begin
                if (i_item.valid) n_state = hkrt_pkg::ST_EXEC;
            end
            hkrt_pkg::ST_EXEC: begin
                n_state = w_key_op ? hkrt_pkg::ST_SCAN : hkrt_pkg::ST_RESP;
            end
            hkrt_pkg::ST_SCAN: begin
                if (r_op == hkrt_pkg::OP_ADD_KEY) begin
                    if (w_hit || w_empty || w_last) n_state = hkrt_pkg::ST_RESP;
                end else begin
                    if (w_hit) n_state = hkrt_pkg::ST_SHIFT;
                    else if (w_last) n_state = hkrt_pkg::ST_RESP;
                end
            end
            hkrt_pkg::ST_SHIFT: begin
                if (w_last) n_state = hkrt_pkg::ST_RESP;
            end
            hkrt_pkg::ST_RESP: begin
                if (o_result.ready) n_state = hkrt_pkg::ST_IDLE;
            end
            default: n_state = hkrt_pkg::ST_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        n_idx        = r_idx;
        n_mods       = r_mods;
        n_cons       = r_cons;
        n_kb_dirty   = r_kb_dirty;
        n_cons_dirty = r_cons_dirty;
        w_wr_en      = 1'b0;
        w_wr_data    = 8'd0;
        unique case (r_state)
            hkrt_pkg::ST_EXEC: begin
                n_idx = '0;
                unique case (r_op)
                    hkrt_pkg::OP_ADD_MODS: begin
                        n_mods = r_mods | r_mbits;
                        if ((r_mods | r_mbits) != r_mods) n_kb_dirty = 1'b1;
                    end
                    hkrt_pkg::OP_DEL_MODS: begin
                        n_mods = r_mods & ~r_mbits;
                        if ((r_mods & ~r_mbits) != r_mods) n_kb_dirty = 1'b1;
                    end
                    hkrt_pkg::OP_SET_CONS: begin
                        n_cons = r_usage;
                        if (r_usage != r_cons) n_cons_dirty = 1'b1;
                    end
                    hkrt_pkg::OP_CLR_KB:   n_kb_dirty   = 1'b0;
                    hkrt_pkg::OP_CLR_CONS: n_cons_dirty = 1'b0;
                    default: ;
                endcase
            end
            hkrt_pkg::ST_SCAN: begin
                if (r_op == hkrt_pkg::OP_ADD_KEY) begin
                    // first empty slot takes the key unless it is already present
                    if (!w_hit && w_empty) begin
                        w_wr_en    = 1'b1;
                        w_wr_data  = r_code;
                        n_kb_dirty = 1'b1;
                    end else if (!w_hit && !w_last) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (!w_hit && !w_last) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            hkrt_pkg::ST_SHIFT: begin
                // close the gap one slot per cycle, clear the last slot
                w_wr_en = 1'b1;
                if (w_last) begin
                    w_wr_data  = 8'd0;
                    n_kb_dirty = 1'b1;
                end else begin
                    w_wr_data = r_slots[r_idx + IDX_W'(1)];
                    n_idx     = r_idx + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hkrt_pkg::ST_IDLE;
            r_idx        <= '0;
            r_mods       <= 8'd0;
            r_cons       <= 16'd0;
            r_kb_dirty   <= 1'b0;
            r_cons_dirty <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) r_slots[i] <= 8'd0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_mods       <= n_mods;
            r_cons       <= n_cons;
            r_kb_dirty   <= n_kb_dirty;
            r_cons_dirty <= n_cons_dirty;
            if (w_wr_en) r_slots[r_idx] <= w_wr_data;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op    <= i_item.op;
            r_code  <= i_item.key_code;
            r_mbits <= i_item.modifier_bits;
            r_usage <= i_item.consumer_value;
        end
    end

    // Visible slots, zero beyond KEY_SLOTS
    for (genvar j = 0; j < hkrt_pkg::OUT_SLOTS; j++) begin : g_view
        if (j < KEY_SLOTS) begin : g_real
            assign w_view[j] = r_slots[j];
        end else begin : g_zero
            assign w_view[j] = 8'd0;
        end
    end

    // Channel outputs
    assign i_item.ready            = (r_state == hkrt_pkg::ST_IDLE);
    assign o_result.valid          = (r_state == hkrt_pkg::ST_RESP);
    assign o_result.key_slot_0     = w_view[0];
    assign o_result.key_slot_1     = w_view[1];
    assign o_result.key_slot_2     = w_view[2];
    assign o_result.key_slot_3     = w_view[3];
    assign o_result.key_slot_4     = w_view[4];
    assign o_result.key_slot_5     = w_view[5];
    assign o_result.modifier_state = r_mods;
    assign o_result.consumer_state = r_cons;
    assign o_result.keyboard_dirty = r_kb_dirty;
    assign o_result.consumer_dirty = r_cons_dirty;

`ifndef NO_ASSERTIONS
    // no new request while a result waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !i_item.ready)
        else $error("request accepted while result pending");

    // shift-down only for a key removal
    a_shift_on_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hkrt_pkg::ST_SHIFT) |-> (r_op == hkrt_pkg::OP_DEL_KEY))
        else $error("slot shift outside key removal");

    // keyboard flag is set only by a keyboard request
    a_kb_dirty_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_kb_dirty) |-> ((r_op == hkrt_pkg::OP_ADD_KEY) ||
            (r_op == hkrt_pkg::OP_DEL_KEY) || (r_op == hkrt_pkg::OP_ADD_MODS) ||
            (r_op == hkrt_pkg::OP_DEL_MODS)))
        else $error("keyboard flag set by non-keyboard request");

    // consumer word changes only under a consumer request
    a_cons_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cons) |-> (r_op == hkrt_pkg::OP_SET_CONS) && r_cons_dirty)
        else $error("consumer word changed unexpectedly");
`endif

endmodule

// File: dv/tb_hid_keyboard_report_tracker.sv
// Self-checking testbench for the HID keyboard report tracker.
`timescale 1ns / 1ps

module tb_hid_keyboard_report_tracker;

    localparam int unsigned KEY_SLOTS      = 6;
    localparam logic [2:0]  OP_UNUSED      = 3'd7;
    localparam int unsigned RANDOM_ITEMS   = 800;
    localparam int unsigned IDLE_PERCENT   = 22;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 40;

    // One request item as driven on the item channel
    typedef struct {
        logic [2:0]  op;
        logic [7:0]  key_code;
        logic [7:0]  modifier_bits;
        logic [15:0] consumer_value;
    } t_req;

    // One report snapshot as carried on the result channel
    typedef struct {
        logic [7:0]  slot [hkrt_pkg::OUT_SLOTS];
        logic [7:0]  modifier_state;
        logic [15:0] consumer_state;
        logic        keyboard_dirty;
        logic        consumer_dirty;
    } t_report;

    // Tracks the report state and the queue of reports still to arrive
    class t_report_checker;
        logic [7:0]  slots [KEY_SLOTS];
        logic [7:0]  mods;
        logic [15:0] cons;
        logic        kb_flag;
        logic        cons_flag;
        t_report     expected_reports [$];
        int unsigned errors;

        function new();
            foreach (slots[i]) slots[i] = 8'h00;
            mods      = 8'h00;
            cons      = 16'h0000;
            kb_flag   = 1'b0;
            cons_flag = 1'b0;
            errors    = 0;
        endfunction

        // Fill the first empty slot unless the key is zero, present or the report is full
        function void insert_key(logic [7:0] code);
            int pos;
            pos = -1;
            if (code == 8'h00) return;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (slots[i] == code) return;
                if (slots[i] == 8'h00) begin
                    pos = i;
                    break;
                end
            end
            if (pos < 0) return;
            slots[pos] = code;
            kb_flag    = 1'b1;
        endfunction

        // Remove a key and close the gap behind it
        function void delete_key(logic [7:0] code);
            int pos;
            pos = -1;
            if (code == 8'h00) return;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (slots[i] == code) begin
                    pos = i;
                    break;
                end
            end
            if (pos < 0) return;
            for (int k = pos; k + 1 < KEY_SLOTS; k++) slots[k] = slots[k + 1];
            slots[KEY_SLOTS - 1] = 8'h00;
            kb_flag = 1'b1;
        endfunction

        function void update_mods(logic [7:0] nxt);
            if (nxt != mods) begin
                mods    = nxt;
                kb_flag = 1'b1;
            end
        endfunction

        // Apply an accepted request and queue the report it yields
        function void apply_request(t_req r);
            t_report e;
            case (r.op)
                hkrt_pkg::OP_ADD_KEY:  insert_key(r.key_code);
                hkrt_pkg::OP_DEL_KEY:  delete_key(r.key_code);
                hkrt_pkg::OP_ADD_MODS: update_mods(mods | r.modifier_bits);
                hkrt_pkg::OP_DEL_MODS: update_mods(mods & ~r.modifier_bits);
                hkrt_pkg::OP_SET_CONS: begin
                    if (r.consumer_value != cons) begin
                        cons      = r.consumer_value;
                        cons_flag = 1'b1;
                    end
                end
                hkrt_pkg::OP_CLR_KB:   kb_flag   = 1'b0;
                hkrt_pkg::OP_CLR_CONS: cons_flag = 1'b0;
                default: ;
            endcase
            for (int j = 0; j < hkrt_pkg::OUT_SLOTS; j++)
                e.slot[j] = (j < KEY_SLOTS) ? slots[j] : 8'h00;
            e.modifier_state = mods;
            e.consumer_state = cons;
            e.keyboard_dirty = kb_flag;
            e.consumer_dirty = cons_flag;
            expected_reports.push_back(e);
        endfunction

        function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare an accepted report with the oldest one queued
        function void check_report(t_report a);
            t_report e;
            if (expected_reports.size() == 0) begin
                $error("result item with no request outstanding");
                errors++;
                return;
            end
            e = expected_reports.pop_front();
            for (int j = 0; j < hkrt_pkg::OUT_SLOTS; j++) begin
                cmp_field($sformatf("key_slot_%0d", j), 16'(e.slot[j]), 16'(a.slot[j]));
            end
            cmp_field("modifier_state", 16'(e.modifier_state), 16'(a.modifier_state));
            cmp_field("consumer_state", e.consumer_state, a.consumer_state);
            cmp_field("keyboard_dirty", 16'(e.keyboard_dirty), 16'(a.keyboard_dirty));
            cmp_field("consumer_dirty", 16'(e.consumer_dirty), 16'(a.consumer_dirty));
        endfunction

        function void check_drained();
            if (expected_reports.size() != 0) begin
                $error("%0d result items never arrived", expected_reports.size());
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic no_idle;

    hkrt_item_if   item_if ();
    hkrt_result_if res_if ();

    t_report_checker sb = new();

    hid_keyboard_report_tracker #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if.sink),
        .o_result (res_if.source)
    );

    always #6 i_clk = ~i_clk;

    // Request with the used field set and the others random
    function automatic t_req make_req(logic [2:0] op, logic [15:0] val);
        t_req r;
        r.op             = op;
        r.key_code       = 8'($urandom);
        r.modifier_bits  = 8'($urandom);
        r.consumer_value = 16'($urandom);
        case (op) inside
            hkrt_pkg::OP_ADD_KEY, hkrt_pkg::OP_DEL_KEY:   r.key_code      = val[7:0];
            hkrt_pkg::OP_ADD_MODS, hkrt_pkg::OP_DEL_MODS: r.modifier_bits = val[7:0];
            hkrt_pkg::OP_SET_CONS:                        r.consumer_value = val;
            default: ;
        endcase
        return r;
    endfunction

    // Drive one request, with random idle cycles first, until it is accepted
    task automatic send_req(t_req r);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid          <= 1'b1;
        item_if.op             <= r.op;
        item_if.key_code       <= r.key_code;
        item_if.modifier_bits  <= r.modifier_bits;
        item_if.consumer_value <= r.consumer_value;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        sb.apply_request(r);
    endtask

    task automatic send_op(logic [2:0] op, logic [15:0] val);
        send_req(make_req(op, val));
    endtask

    // Key codes mostly from a small pool so that duplicates and removals hit
    function automatic logic [7:0] pick_key();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 10) return 8'h00;
        if (p < 70) return 8'($urandom_range(1, 10));
        return 8'($urandom);
    endfunction

    function automatic t_req random_req();
        t_req        r;
        int unsigned p;
        r.op             = OP_UNUSED;
        r.key_code       = 8'($urandom);
        r.modifier_bits  = 8'($urandom);
        r.consumer_value = 16'($urandom);
        p = $urandom_range(99);
        if (p < 35) begin
            r.op       = hkrt_pkg::OP_ADD_KEY;
            r.key_code = pick_key();
        end else if (p < 60) begin
            r.op       = hkrt_pkg::OP_DEL_KEY;
            r.key_code = pick_key();
        end else if (p < 70) begin
            r.op = hkrt_pkg::OP_ADD_MODS;
        end else if (p < 80) begin
            r.op = hkrt_pkg::OP_DEL_MODS;
        end else if (p < 88) begin
            r.op = hkrt_pkg::OP_SET_CONS;
            if ($urandom_range(1)) r.consumer_value = 16'($urandom_range(0, 3));
        end else if (p < 93) begin
            r.op = hkrt_pkg::OP_CLR_KB;
        end else if (p < 98) begin
            r.op = hkrt_pkg::OP_CLR_CONS;
        end
        return r;
    endfunction

    // Result side: random back-pressure, check every accepted report
    initial begin
        t_report a;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                a.slot[0]        = res_if.key_slot_0;
                a.slot[1]        = res_if.key_slot_1;
                a.slot[2]        = res_if.key_slot_2;
                a.slot[3]        = res_if.key_slot_3;
                a.slot[4]        = res_if.key_slot_4;
                a.slot[5]        = res_if.key_slot_5;
                a.modifier_state = res_if.modifier_state;
                a.consumer_state = res_if.consumer_state;
                a.keyboard_dirty = res_if.keyboard_dirty;
                a.consumer_dirty = res_if.consumer_dirty;
                sb.check_report(a);
            end
            res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on cycles without any accepted item
    initial begin
        int unsigned stall;
        stall = 0;
        while (stall < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        no_idle                = 1'b0;
        i_rst_n                <= 1'b0;
        item_if.valid          <= 1'b0;
        item_if.op             <= hkrt_pkg::OP_ADD_KEY;
        item_if.key_code       <= 8'h00;
        item_if.modifier_bits  <= 8'h00;
        item_if.consumer_value <= 16'h0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero key, duplicate, full report, removal cases
        send_op(hkrt_pkg::OP_ADD_KEY, 16'h00);
        send_op(hkrt_pkg::OP_DEL_KEY, 16'h00);
        send_op(hkrt_pkg::OP_ADD_KEY, 16'h04);
        send_op(hkrt_pkg::OP_ADD_KEY, 16'hFF);
        send_op(hkrt_pkg::OP_ADD_KEY, 16'h04);
        send_op(hkrt_pkg::OP_ADD_KEY, 16'h80);
        send_op(hkrt_pkg::OP_ADD_KEY, 16'h01);
        send_op(hkrt_pkg::OP_ADD_KEY, 16'h7F);
        send_op(hkrt_pkg::OP_ADD_KEY, 16'h2A);
        send_op(hkrt_pkg::OP_CLR_KB, 16'h0);
        send_op(hkrt_pkg::OP_ADD_KEY, 16'h55);
        send_op(hkrt_pkg::OP_DEL_KEY, 16'h33);
        send_op(hkrt_pkg::OP_DEL_KEY, 16'h80);
        send_op(hkrt_pkg::OP_DEL_KEY, 16'h04);
        send_op(hkrt_pkg::OP_DEL_KEY, 16'h2A);
        // Directed: modifiers with and without effect
        send_op(hkrt_pkg::OP_CLR_KB, 16'h0);
        send_op(hkrt_pkg::OP_ADD_MODS, 16'h00);
        send_op(hkrt_pkg::OP_ADD_MODS, 16'hFF);
        send_op(hkrt_pkg::OP_ADD_MODS, 16'h11);
        send_op(hkrt_pkg::OP_DEL_MODS, 16'h0F);
        send_op(hkrt_pkg::OP_DEL_MODS, 16'hFF);
        send_op(hkrt_pkg::OP_CLR_KB, 16'h0);
        // Directed: consumer word, same value, flag clear, unused op code
        send_op(hkrt_pkg::OP_SET_CONS, 16'hFFFF);
        send_op(hkrt_pkg::OP_SET_CONS, 16'hFFFF);
        send_op(hkrt_pkg::OP_CLR_CONS, 16'h0);
        send_op(hkrt_pkg::OP_SET_CONS, 16'h0000);
        send_op(OP_UNUSED, 16'h0);

        // Random part, with one stretch free of idling on both sides
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 350 && n < 500);
            send_req(random_req());
        end
        no_idle       = 1'b0;
        item_if.valid <= 1'b0;

        while (sb.expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/hkrt_pkg.sv
hdl/hkrt_item_if.sv
hdl/hkrt_result_if.sv
hdl/hid_keyboard_report_tracker.sv
dv/tb_hid_keyboard_report_tracker.sv
